[hw/rtl/pfn_pkg.sv]
// Package: shared types, constants and the finished-polygon record for the face normal block.
package pfn_pkg;

  localparam int MaxPolygonVertices = 256;
  localparam int CountW = $clog2(MaxPolygonVertices + 1);
  localparam int CoordW = 16;
  localparam int SumW = 44;
  localparam int RawW = 45;
  localparam int MagW = 31;
  localparam int SqW = 64;
  localparam int LenW = 32;
  localparam int NormW = 16;
  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    StOk = 2'd0,
    StFewVerts = 2'd1,
    StZeroLen = 2'd2,
    StTooMany = 2'd3
  } status_e;

  // Raw normal of one finished polygon, handed from front to back.
  typedef struct packed {
    logic signed [RawW-1:0] raw_x;
    logic signed [RawW-1:0] raw_y;
    logic signed [RawW-1:0] raw_z;
    status_e                status;
  } poly_t;

endpackage

[hw/rtl/pfn_front.sv]
// Front end: accepts vertices, keeps polygon state and Newell sums, emits raw normals.
module pfn_front import pfn_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     ccw_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [CoordW-1:0] x_i,
  input  logic signed [CoordW-1:0] y_i,
  input  logic signed [CoordW-1:0] z_i,
  input  logic                     last_i,
  output logic                     poly_valid_o,
  input  logic                     poly_ready_i,
  output poly_t                    poly_o
);

  // Phases: accept vertices; at a last vertex, multiply then sum then emit.
  typedef enum logic [1:0] {SAccept, SMul, SSum, SEmit} state_e;

  state_e state_q, state_d;
  logic signed [CoordW-1:0] fx_q, fy_q, fz_q, sx_q, sy_q, sz_q, px_q, py_q, pz_q;
  logic [CountW-1:0] cnt_q;
  logic ovf_q;
  logic signed [SumW-1:0] nx_q, ny_q, nz_q;
  // edge products for one edge (previous -> current), registered
  logic signed [2*CoordW+1:0] ex_q, ey_q, ez_q;
  logic edge_q;
  logic signed [2*CoordW+1:0] t0_q, t1_q, t2_q, t3_q, t4_q, t5_q;
  poly_t poly_q;

  logic acc;
  logic signed [CoordW:0] dy, dz, dx, sy, sz, sx;
  logic signed [CoordW:0] ax, ay, az, bx, by, bz;

  assign in_ready_o = (state_q == SAccept) && !edge_q;
  assign acc = in_valid_i && in_ready_o;
  assign poly_valid_o = (state_q == SEmit);
  assign poly_o = poly_q;

  // products of the closing edge (or the triangle terms) are built in SMul
  always_comb begin
    if (state_q == SAccept) begin
      dx = {px_q[CoordW-1], px_q} - {x_i[CoordW-1], x_i};
      dy = {py_q[CoordW-1], py_q} - {y_i[CoordW-1], y_i};
      dz = {pz_q[CoordW-1], pz_q} - {z_i[CoordW-1], z_i};
      sx = {px_q[CoordW-1], px_q} + {x_i[CoordW-1], x_i};
      sy = {py_q[CoordW-1], py_q} + {y_i[CoordW-1], y_i};
      sz = {pz_q[CoordW-1], pz_q} + {z_i[CoordW-1], z_i};
    end else begin
      dx = {px_q[CoordW-1], px_q} - {fx_q[CoordW-1], fx_q};
      dy = {py_q[CoordW-1], py_q} - {fy_q[CoordW-1], fy_q};
      dz = {pz_q[CoordW-1], pz_q} - {fz_q[CoordW-1], fz_q};
      sx = {px_q[CoordW-1], px_q} + {fx_q[CoordW-1], fx_q};
      sy = {py_q[CoordW-1], py_q} + {fy_q[CoordW-1], fy_q};
      sz = {pz_q[CoordW-1], pz_q} + {fz_q[CoordW-1], fz_q};
    end
    // triangle edges about the middle vertex, swapped for clockwise winding
    if (ccw_i) begin
      ax = {px_q[CoordW-1], px_q} - {sx_q[CoordW-1], sx_q};
      ay = {py_q[CoordW-1], py_q} - {sy_q[CoordW-1], sy_q};
      az = {pz_q[CoordW-1], pz_q} - {sz_q[CoordW-1], sz_q};
      bx = {fx_q[CoordW-1], fx_q} - {sx_q[CoordW-1], sx_q};
      by = {fy_q[CoordW-1], fy_q} - {sy_q[CoordW-1], sy_q};
      bz = {fz_q[CoordW-1], fz_q} - {sz_q[CoordW-1], sz_q};
    end else begin
      bx = {px_q[CoordW-1], px_q} - {sx_q[CoordW-1], sx_q};
      by = {py_q[CoordW-1], py_q} - {sy_q[CoordW-1], sy_q};
      bz = {pz_q[CoordW-1], pz_q} - {sz_q[CoordW-1], sz_q};
      ax = {fx_q[CoordW-1], fx_q} - {sx_q[CoordW-1], sx_q};
      ay = {fy_q[CoordW-1], fy_q} - {sy_q[CoordW-1], sy_q};
      az = {fz_q[CoordW-1], fz_q} - {sz_q[CoordW-1], sz_q};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      SAccept: if (acc && last_i) state_d = SMul;
      SMul:    state_d = SSum;
      SSum:    state_d = SEmit;
      SEmit:   if (poly_ready_i) state_d = SAccept;
      default: state_d = SAccept;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SAccept;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      edge_q  <= 1'b0;
      nx_q    <= '0;
      ny_q    <= '0;
      nz_q    <= '0;
      fx_q <= '0; fy_q <= '0; fz_q <= '0;
      sx_q <= '0; sy_q <= '0; sz_q <= '0;
      px_q <= '0; py_q <= '0; pz_q <= '0;
    end else begin
      state_q <= state_d;
      // pending edge product joins the sums in the cycle after it is registered
      if (edge_q) begin
        nx_q <= nx_q + SumW'(ex_q);
        ny_q <= ny_q + SumW'(ey_q);
        nz_q <= nz_q + SumW'(ez_q);
      end
      edge_q <= acc && (cnt_q != '0) && (cnt_q != CountW'(MaxPolygonVertices));
      if (acc) begin
        if (cnt_q == CountW'(MaxPolygonVertices)) begin
          ovf_q <= 1'b1;
        end else begin
          if (cnt_q == '0) begin
            fx_q <= x_i; fy_q <= y_i; fz_q <= z_i;
          end else begin
            ex_q   <= dy * sz;
            ey_q   <= dz * sx;
            ez_q   <= dx * sy;
            if (cnt_q == CountW'(1)) begin
              sx_q <= x_i; sy_q <= y_i; sz_q <= z_i;
            end
          end
          px_q <= x_i; py_q <= y_i; pz_q <= z_i;
          cnt_q <= cnt_q + CountW'(1);
        end
      end
      if (state_q == SMul) begin
        t0_q <= ay * bz; t1_q <= az * by;
        t2_q <= az * bx; t3_q <= ax * bz;
        t4_q <= ax * by; t5_q <= ay * bx;
        ex_q <= dy * sz; ey_q <= dz * sx; ez_q <= dx * sy;
      end
      if (state_q == SSum) begin
        if (ovf_q) begin
          poly_q.status <= StTooMany;
        end else if (cnt_q < CountW'(3)) begin
          poly_q.status <= StFewVerts;
        end else begin
          poly_q.status <= StOk;
        end
        if (cnt_q == CountW'(3)) begin
          poly_q.raw_x <= RawW'(t0_q) - RawW'(t1_q);
          poly_q.raw_y <= RawW'(t2_q) - RawW'(t3_q);
          poly_q.raw_z <= RawW'(t4_q) - RawW'(t5_q);
        end else if (ccw_i) begin
          poly_q.raw_x <= RawW'(nx_q) + RawW'(ex_q);
          poly_q.raw_y <= RawW'(ny_q) + RawW'(ey_q);
          poly_q.raw_z <= RawW'(nz_q) + RawW'(ez_q);
        end else begin
          poly_q.raw_x <= -(RawW'(nx_q) + RawW'(ex_q));
          poly_q.raw_y <= -(RawW'(ny_q) + RawW'(ey_q));
          poly_q.raw_z <= -(RawW'(nz_q) + RawW'(ez_q));
        end
      end
      if (state_q == SEmit && poly_ready_i) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
        nx_q <= '0; ny_q <= '0; nz_q <= '0;
        fx_q <= '0; fy_q <= '0; fz_q <= '0;
        sx_q <= '0; sy_q <= '0; sz_q <= '0;
        px_q <= '0; py_q <= '0; pz_q <= '0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountW'(MaxPolygonVertices))
    else $error("vertex count beyond bound");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SAccept) |-> !in_ready_o)
    else $error("vertex accepted during finish");
  a_emit_after_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(poly_valid_o) |-> $past(state_q) == SSum)
    else $error("emit without sum phase");

endmodule

[hw/rtl/pfn_queue.sv]
// Short FIFO of raw polygon normals between front and back.
module pfn_queue import pfn_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  output logic  wr_ready_o,
  input  poly_t wr_data_i,
  output logic  rd_valid_o,
  input  logic  rd_ready_i,
  output poly_t rd_data_o
);

  localparam int PtrW = $clog2(QueueDepth);

  poly_t            mem_q [QueueDepth];
  logic [PtrW-1:0]  wp_q, rp_q;
  logic [PtrW:0]    cnt_q;
  logic             wr, rd;

  assign wr_ready_o = cnt_q != (PtrW+1)'(QueueDepth);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + PtrW'(1);
      if (rd) rp_q <= rp_q + PtrW'(1);
      cnt_q <= cnt_q + (PtrW+1)'(wr) - (PtrW+1)'(rd);
    end
  end

  a_count_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(QueueDepth))
    else $error("queue count overrun");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr && !rd) |=> cnt_q == $past(cnt_q) + (PtrW+1)'(1))
    else $error("queue count mismatch");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> wp_q == rp_q)
    else $error("empty queue with pointer gap");

endmodule

[hw/rtl/pfn_back.sv]
// Back end: scales raw normal, integer square root, three serial dividers, output register.
module pfn_back import pfn_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  poly_t                   in_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [NormW-1:0] nx_o,
  output logic signed [NormW-1:0] ny_o,
  output logic signed [NormW-1:0] nz_o,
  output status_e                 status_o
);

  typedef enum logic [2:0] {BIdle, BShift, BSq, BSqrt, BDiv, BOut} state_e;

  localparam int RemW = MagW + 16;
  localparam int QW = 15;

  state_e state_q;
  logic [RawW-1:0] mx_q, my_q, mz_q;
  logic sgx_q, sgy_q, sgz_q;
  status_e st_q;
  logic [SqW-1:0] sq_q, rad_q, res_q, bit_q;
  logic [5:0] step_q;
  logic [RemW-1:0] rx_q, ry_q, rz_q;
  logic [QW-1:0] qx_q, qy_q, qz_q;
  logic [LenW-1:0] len_q;
  logic signed [NormW-1:0] ox_q, oy_q, oz_q;
  status_e ost_q;
  logic ov_q;
  logic [2*MagW-1:0] px, py, pz;
  logic [SqW-1:0] trial;
  logic [RemW-1:0] lenx;
  logic [RawW:0] numx, numy, numz;

  assign in_ready_o  = state_q == BIdle;
  assign out_valid_o = ov_q;
  assign nx_o = ox_q;
  assign ny_o = oy_q;
  assign nz_o = oz_q;
  assign status_o = ost_q;

  assign px = mx_q[MagW-1:0] * mx_q[MagW-1:0];
  assign py = my_q[MagW-1:0] * my_q[MagW-1:0];
  assign pz = mz_q[MagW-1:0] * mz_q[MagW-1:0];
  assign trial = res_q + bit_q;
  assign lenx = RemW'(len_q);
  // dividend m*2^14 + L/2 can carry one bit past RawW
  assign numx = {1'b0, mx_q[MagW-1:0], 14'd0} + (RawW+1)'(len_q >> 1);
  assign numy = {1'b0, my_q[MagW-1:0], 14'd0} + (RawW+1)'(len_q >> 1);
  assign numz = {1'b0, mz_q[MagW-1:0], 14'd0} + (RawW+1)'(len_q >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BIdle;
      ov_q    <= 1'b0;
    end else begin
      if (ov_q && out_ready_i && state_q != BOut) ov_q <= 1'b0;
      case (state_q)
        BIdle: if (in_valid_i) begin
          sgx_q <= in_i.raw_x[RawW-1];
          sgy_q <= in_i.raw_y[RawW-1];
          sgz_q <= in_i.raw_z[RawW-1];
          mx_q <= in_i.raw_x[RawW-1] ? -in_i.raw_x : in_i.raw_x;
          my_q <= in_i.raw_y[RawW-1] ? -in_i.raw_y : in_i.raw_y;
          mz_q <= in_i.raw_z[RawW-1] ? -in_i.raw_z : in_i.raw_z;
          st_q <= in_i.status;
          state_q <= BShift;
        end
        BShift: begin
          // one bit of right shift per cycle until all below 2^31
          if (st_q != StOk) begin
            state_q <= BOut;
          end else if ((mx_q | my_q | mz_q) == '0) begin
            st_q <= StZeroLen;
            state_q <= BOut;
          end else if ((mx_q[RawW-1:MagW] | my_q[RawW-1:MagW] | mz_q[RawW-1:MagW]) != '0)
          begin
            mx_q <= mx_q >> 1;
            my_q <= my_q >> 1;
            mz_q <= mz_q >> 1;
          end else begin
            sq_q <= SqW'(px);
            step_q <= '0;
            state_q <= BSq;
          end
        end
        BSq: begin
          step_q <= step_q + 6'd1;
          if (step_q == 6'd0) sq_q <= sq_q + SqW'(py);
          else begin
            rad_q <= sq_q + SqW'(pz);
            res_q <= '0;
            bit_q <= SqW'(1) << (SqW-2);
            state_q <= BSqrt;
          end
        end
        BSqrt: begin
          if (bit_q == '0) begin
            len_q <= LenW'(res_q);
            rx_q <= RemW'(mx_q[MagW-1:0]);
            ry_q <= RemW'(my_q[MagW-1:0]);
            rz_q <= RemW'(mz_q[MagW-1:0]);
            qx_q <= '0; qy_q <= '0; qz_q <= '0;
            step_q <= '0;
            state_q <= BDiv;
          end else begin
            if (rad_q >= trial) begin
              rad_q <= rad_q - trial;
              res_q <= (res_q >> 1) + bit_q;
            end else begin
              res_q <= res_q >> 1;
            end
            bit_q <= bit_q >> 2;
          end
        end
        BDiv: begin
          // restoring division of m*2^14 + L/2 by L, one quotient bit per cycle;
          // the carry bit of the dividend starts the remainder
          if (step_q == '0) begin
            rx_q <= RemW'(numx[RawW]);
            ry_q <= RemW'(numy[RawW]);
            rz_q <= RemW'(numz[RawW]);
            mx_q <= numx[RawW-1:0];
            my_q <= numy[RawW-1:0];
            mz_q <= numz[RawW-1:0];
            step_q <= 6'd1;
          end else if (step_q <= 6'(RawW)) begin
            step_q <= step_q + 6'd1;
            // shift in dividend bit, compare, subtract
            if ({rx_q, mx_q[RawW-1]} >= {1'b0, lenx}) begin
              rx_q <= RemW'({rx_q, mx_q[RawW-1]} - {1'b0, lenx});
              qx_q <= {qx_q[QW-2:0], 1'b1};
            end else begin
              rx_q <= {rx_q[RemW-2:0], mx_q[RawW-1]};
              qx_q <= {qx_q[QW-2:0], 1'b0};
            end
            if ({ry_q, my_q[RawW-1]} >= {1'b0, lenx}) begin
              ry_q <= RemW'({ry_q, my_q[RawW-1]} - {1'b0, lenx});
              qy_q <= {qy_q[QW-2:0], 1'b1};
            end else begin
              ry_q <= {ry_q[RemW-2:0], my_q[RawW-1]};
              qy_q <= {qy_q[QW-2:0], 1'b0};
            end
            if ({rz_q, mz_q[RawW-1]} >= {1'b0, lenx}) begin
              rz_q <= RemW'({rz_q, mz_q[RawW-1]} - {1'b0, lenx});
              qz_q <= {qz_q[QW-2:0], 1'b1};
            end else begin
              rz_q <= {rz_q[RemW-2:0], mz_q[RawW-1]};
              qz_q <= {qz_q[QW-2:0], 1'b0};
            end
            mx_q <= mx_q << 1;
            my_q <= my_q << 1;
            mz_q <= mz_q << 1;
          end else begin
            state_q <= BOut;
          end
        end
        BOut: if (!ov_q || out_ready_i) begin
          ov_q  <= 1'b1;
          ost_q <= st_q;
          if (st_q == StOk) begin
            ox_q <= sgx_q ? -NormW'(qx_q) : NormW'(qx_q);
            oy_q <= sgy_q ? -NormW'(qy_q) : NormW'(qy_q);
            oz_q <= sgz_q ? -NormW'(qz_q) : NormW'(qz_q);
          end else begin
            ox_q <= '0; oy_q <= '0; oz_q <= '0;
          end
          state_q <= BIdle;
        end
        default: state_q <= BIdle;
      endcase
    end
  end

  a_zero_on_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ost_q != StOk) |-> (ox_q == '0 && oy_q == '0 && oz_q == '0))
    else $error("nonzero normal with error status");
  a_unit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (ox_q <= 16'sd16384 && ox_q >= -16'sd16384))
    else $error("normal x out of range");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> ov_q)
    else $error("result dropped");

endmodule

[hw/rtl/polygon_face_normal.sv]
// Top level: polygon unit face normal from a streamed vertex list.
// Input: a polygon's second vertex may follow its first at once; after each later vertex
// within the vertex bound, ready drops while its edge product joins the sums. After each
// last vertex the front end closes out in SMul, SSum and SEmit. Back end: one polygon at
// a time behind a 2-entry queue (up to 14 shift steps, square root, division); an error
// status goes straight to output. rst_ni idles every block; counter_clockwise resets to 1.
module polygon_face_normal import pfn_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // coord_x, coord_y, coord_z
  input  logic        s_axis_tlast,   // last_vertex
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // normal_x, normal_y, normal_z, status, 6 zero bits
);

  logic ccw_q;
  logic pv, pr, qv, qr;
  poly_t pd, qd;
  logic signed [NormW-1:0] nx, ny, nz;
  status_e st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ccw_q <= 1'b1;
    else if (cfg_we_i) ccw_q <= cfg_wdata_i;
  end

  pfn_front u_front (
    .clk_i, .rst_ni, .ccw_i(ccw_q),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .x_i(s_axis_tdata[15:0]), .y_i(s_axis_tdata[31:16]), .z_i(s_axis_tdata[47:32]),
    .last_i(s_axis_tlast),
    .poly_valid_o(pv), .poly_ready_i(pr), .poly_o(pd)
  );

  pfn_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(pv), .wr_ready_o(pr), .wr_data_i(pd),
    .rd_valid_o(qv), .rd_ready_i(qr), .rd_data_o(qd)
  );

  pfn_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i(qv), .in_ready_o(qr), .in_i(qd),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .nx_o(nx), .ny_o(ny), .nz_o(nz), .status_o(st)
  );

  assign m_axis_tdata = {6'd0, st, nz, ny, nx};

endmodule

[tb/testbench.sv]
// Testbench for polygon_face_normal: streamed polygons checked against an in-bench normal predictor.
module testbench;
  import pfn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    status_e            st;
  } face_normal_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // coord_x, coord_y, coord_z
  logic        s_axis_tlast = 1'b0; // last_vertex
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // normal_x, normal_y, normal_z, status, 6 zero bits

  polygon_face_normal dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  bit            winding_ccw = 1'b1;
  int            vtx_first[3];
  int            vtx_second[3];
  int            vtx_prev[3];
  int unsigned   vtx_count;
  longint        newell[3];
  bit            too_many;
  face_normal_t  normals_due[$];

  int errors = 0;
  bit idle_on = 1'b1;
  int hold_req = 0;
  int stall_left = 0;

  function automatic void add_edge(int a[3], int b[3]);
    newell[0] += longint'(a[1] - b[1]) * longint'(a[2] + b[2]);
    newell[1] += longint'(a[2] - b[2]) * longint'(a[0] + b[0]);
    newell[2] += longint'(a[0] - b[0]) * longint'(a[1] + b[1]);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void clear_polygon();
    for (int i = 0; i < 3; i++) begin
      vtx_first[i] = 0;
      vtx_second[i] = 0;
      vtx_prev[i] = 0;
      newell[i] = 0;
    end
    vtx_count = 0;
    too_many = 1'b0;
  endfunction

  function automatic void predict_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                         bit last);
    int v[3];
    longint raw[3];
    longint a[3];
    longint b[3];
    longint unsigned mag[3];
    longint unsigned maxmag;
    longint unsigned sumsq;
    longint unsigned len;
    longint q;
    int shift;
    face_normal_t res;
    v[0] = $signed(x);
    v[1] = $signed(y);
    v[2] = $signed(z);
    if (vtx_count >= MaxPolygonVertices) begin
      too_many = 1'b1;
    end else begin
      if (vtx_count == 0) begin
        vtx_first = v;
      end else begin
        add_edge(vtx_prev, v);
        if (vtx_count == 1) vtx_second = v;
      end
      vtx_prev = v;
      vtx_count++;
    end
    if (!last) return;
    res.nx = '0;
    res.ny = '0;
    res.nz = '0;
    res.st = StOk;
    if (too_many) begin
      res.st = StTooMany;
    end else if (vtx_count < 3) begin
      res.st = StFewVerts;
    end else begin
      if (vtx_count == 3) begin
        for (int i = 0; i < 3; i++) begin
          a[i] = vtx_prev[i] - vtx_second[i];
          b[i] = vtx_first[i] - vtx_second[i];
        end
        if (!winding_ccw) begin
          for (int i = 0; i < 3; i++) begin
            q = a[i];
            a[i] = b[i];
            b[i] = q;
          end
        end
        raw[0] = a[1] * b[2] - a[2] * b[1];
        raw[1] = a[2] * b[0] - a[0] * b[2];
        raw[2] = a[0] * b[1] - a[1] * b[0];
      end else begin
        add_edge(vtx_prev, vtx_first);
        for (int i = 0; i < 3; i++) raw[i] = winding_ccw ? newell[i] : -newell[i];
      end
      maxmag = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = raw[i] < 0 ? longint'(-raw[i]) : raw[i];
        if (mag[i] > maxmag) maxmag = mag[i];
      end
      if (maxmag == 0) begin
        res.st = StZeroLen;
      end else begin
        shift = 0;
        while ((maxmag >> shift) >= 64'h8000_0000) shift++;
        sumsq = 0;
        for (int i = 0; i < 3; i++) begin
          mag[i] >>= shift;
          sumsq += mag[i] * mag[i];
        end
        len = int_sqrt(sumsq);
        for (int i = 0; i < 3; i++) begin
          q = longint'((mag[i] * 16384 + len / 2) / len);
          if (raw[i] < 0) q = -q;
          if (i == 0) res.nx = q[15:0];
          else if (i == 1) res.ny = q[15:0];
          else res.nz = q[15:0];
        end
      end
    end
    normals_due.push_back(res);
    clear_polygon();
  endfunction

  // result checker
  always @(posedge clk_i) begin
    face_normal_t exp_n;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (normals_due.size() == 0) begin
        $error("unexpected result beat: %h", m_axis_tdata);
        errors++;
      end else begin
        exp_n = normals_due.pop_front();
        if (m_axis_tdata[15:0] !== exp_n.nx) begin
          $error("normal_x: expected %0d, got %0d", exp_n.nx, $signed(m_axis_tdata[15:0]));
          errors++;
        end
        if (m_axis_tdata[31:16] !== exp_n.ny) begin
          $error("normal_y: expected %0d, got %0d", exp_n.ny, $signed(m_axis_tdata[31:16]));
          errors++;
        end
        if (m_axis_tdata[47:32] !== exp_n.nz) begin
          $error("normal_z: expected %0d, got %0d", exp_n.nz, $signed(m_axis_tdata[47:32]));
          errors++;
        end
        if (m_axis_tdata[49:48] !== exp_n.st) begin
          $error("status: expected %0d, got %0d", exp_n.st, m_axis_tdata[49:48]);
          errors++;
        end
      end
    end
  end

  // receiver: random stall bursts plus an optional long hold-off
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        m_axis_tready <= 1'b0;
        hold_req--;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(1, 19) - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_vertex(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z, input bit last);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {z, y, x};
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_vertex(x, y, z, last);
  endtask

  // drop valid, wait out every result and let the back end settle
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (normals_due.size() != 0) @(posedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic set_winding(input bit ccw);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= ccw;
    winding_ccw = ccw;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'($urandom_range(0, 8) - 4);
      1: return 16'($urandom_range(0, 2048) - 1024);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_polygon(input int n, input int mode);
    logic [15:0] z0;
    z0 = rand_coord(mode);
    for (int i = 0; i < n; i++)
      send_vertex(rand_coord(mode), rand_coord(mode),
                  (mode == 1 && $urandom_range(0, 1)) ? z0 : rand_coord(mode), i == n - 1);
  endtask

  task automatic test_directed();
    set_winding(1'b1);
    // right triangle with legs of 256 in the xy plane
    send_vertex(16'd0, 16'd0, 16'd0, 1'b0);
    send_vertex(16'd256, 16'd0, 16'd0, 1'b0);
    send_vertex(16'd0, 16'd256, 16'd0, 1'b1);
    // too few vertices: one, then two
    send_vertex(16'h7fff, 16'h8000, 16'h7fff, 1'b1);
    send_vertex(16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_vertex(16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
    // collinear triangle gives zero length
    send_vertex(16'd1, 16'd1, 16'd1, 1'b0);
    send_vertex(16'd2, 16'd2, 16'd2, 1'b0);
    send_vertex(16'd3, 16'd3, 16'd3, 1'b1);
    // extreme-coordinate triangle and quad
    send_vertex(16'h8000, 16'h8000, 16'h7fff, 1'b0);
    send_vertex(16'h7fff, 16'h8000, 16'h8000, 1'b0);
    send_vertex(16'h8000, 16'h7fff, 16'h8000, 1'b1);
    send_vertex(16'h8000, 16'h8000, 16'h0000, 1'b0);
    send_vertex(16'h7fff, 16'h8000, 16'h7fff, 1'b0);
    send_vertex(16'h7fff, 16'h7fff, 16'h0000, 1'b0);
    send_vertex(16'h8000, 16'h7fff, 16'h8000, 1'b1);
    // degenerate quad: all points the same
    repeat (3) send_vertex(16'h1234, 16'hfedc, 16'h0101, 1'b0);
    send_vertex(16'h1234, 16'hfedc, 16'h0101, 1'b1);
  endtask

  task automatic test_clockwise();
    set_winding(1'b0);
    send_vertex(16'd0, 16'd0, 16'd0, 1'b0);
    send_vertex(16'd256, 16'd0, 16'd0, 1'b0);
    send_vertex(16'd0, 16'd256, 16'd0, 1'b1);
    send_polygon(5, 1);
    send_polygon(4, 2);
  endtask

  task automatic test_vertex_bound();
    set_winding(1'b1);
    send_polygon(MaxPolygonVertices, 2);
    send_polygon(MaxPolygonVertices + 1, 2);
    send_polygon(MaxPolygonVertices + 4, 1);
  endtask

  task automatic test_random(input int budget);
    int sent;
    int n;
    int mode;
    sent = 0;
    while (sent < budget) begin
      case ($urandom_range(0, 39))
        0, 1: n = $urandom_range(1, 2);
        2: n = $urandom_range(9, 40);
        default: n = $urandom_range(3, 8);
      endcase
      mode = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 2);
      send_polygon(n, mode);
      sent += n;
    end
  endtask

  task automatic test_backpressure();
    drain();
    hold_req = 400;
    repeat (20) send_polygon(3, 2);
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    clear_polygon();
    test_directed();
    test_clockwise();
    test_vertex_bound();
    set_winding(1'b0);
    test_random(250);
    set_winding(1'b1);
    test_random(250);
    set_winding(1'b0);
    test_random(200);
    set_winding(1'b1);
    test_random(200);
    test_backpressure();
    drain();
    idle_on = 1'b0;
    test_random(150);
    drain();
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/pfn_pkg.sv
hw/rtl/pfn_front.sv
hw/rtl/pfn_queue.sv
hw/rtl/pfn_back.sv
hw/rtl/polygon_face_normal.sv
tb/testbench.sv
